// ===== hdl/ithx_pkg.sv =====
// Shared types, constants and helpers for the IPv4/TCP header extractor.
package ithx_pkg;

    localparam logic [15:0] MAX_FRAME_BYTES = 16'd65535;

    localparam logic [1:0] LINK_ETH  = 2'd0;
    localparam logic [1:0] LINK_SLL  = 2'd1;
    localparam logic [1:0] LINK_RAW  = 2'd2;
    localparam logic [1:0] LINK_NONE = 2'd3;

    localparam logic [4:0] IP_OFF_ETH = 5'd14;
    localparam logic [4:0] IP_OFF_SLL = 5'd16;
    localparam logic [4:0] IP_OFF_RAW = 5'd0;

    localparam logic [5:0] MIN_HDR_LEN  = 6'd20;
    localparam logic [7:0] ETHERTYPE_HI = 8'h08;
    localparam logic [7:0] ETHERTYPE_LO = 8'h00;
    localparam logic [3:0] IP_VERSION   = 4'd4;
    localparam logic [7:0] PROTO_TCP    = 8'd6;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } ithx_in_t;

    typedef struct packed {
        logic        accepted;
        logic [31:0] source_address;
        logic [31:0] dest_address;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic [31:0] sequence_word;
        logic [31:0] ack_word;
        logic [7:0]  tcp_flag_bits;
        logic [15:0] window_size;
        logic [7:0]  payload_start;
        logic [15:0] payload_length;
    } ithx_out_t;

    // Header state of one finished frame, handed from capture to checking.
    typedef struct packed {
        logic [1:0]  link_type;
        logic        overlong;
        logic        ethertype_ok;
        logic [7:0]  version_and_ihl;
        logic [7:0]  protocol_byte;
        logic [15:0] ip_total_length;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [31:0] ports;
        logic [63:0] seq_ack;
        logic [31:0] off_flags_win;
        logic [15:0] cap_len;
    } ithx_snap_t;

    function automatic logic [4:0] ip_start(input logic [1:0] link);
        logic [4:0] off;
        unique case (link)
            LINK_ETH: off = IP_OFF_ETH;
            LINK_SLL: off = IP_OFF_SLL;
            default:  off = IP_OFF_RAW;
        endcase
        return off;
    endfunction

endpackage

// ===== hdl/ithx_capture.sv =====
// Per-byte header field capture and byte counter for the current frame.
module ithx_capture (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [1:0]            link_type,
    input  ithx_pkg::ithx_in_t    in_data,
    input  logic                  in_xfer,
    output ithx_pkg::ithx_snap_t  snap
);
    import ithx_pkg::*;

    logic [15:0] byte_count_reg,   byte_count_next;
    logic        ethertype_ok_reg, ethertype_ok_next;
    logic [7:0]  vih_reg,          vih_next;
    logic [7:0]  proto_reg,        proto_next;
    logic [15:0] total_reg,        total_next;
    logic [31:0] src_reg,          src_next;
    logic [31:0] dst_reg,          dst_next;
    logic [31:0] ports_reg,        ports_next;
    logic [63:0] seq_ack_reg,      seq_ack_next;
    logic [31:0] ofw_reg,          ofw_next;

    logic [4:0]  io;
    logic        overlong;
    logic [15:0] r;
    logic [15:0] t;
    logic [5:0]  ihl4;
    logic [2:0]  sa_lane;
    logic [7:0]  b;

    assign io       = ip_start(link_type);
    assign overlong = (byte_count_reg == MAX_FRAME_BYTES);
    assign b        = in_data.data_byte;
    assign r        = byte_count_reg - {11'd0, io};
    assign ihl4     = {vih_reg[3:0], 2'b00};
    assign t        = r - {10'd0, ihl4};
    assign sa_lane  = t[2:0] - 3'd4;

    always_comb begin
        byte_count_next   = byte_count_reg;
        ethertype_ok_next = ethertype_ok_reg;
        vih_next          = vih_reg;
        proto_next        = proto_reg;
        total_next        = total_reg;
        src_next          = src_reg;
        dst_next          = dst_reg;
        ports_next        = ports_reg;
        seq_ack_next      = seq_ack_reg;
        ofw_next          = ofw_reg;
        if (!overlong) begin
            byte_count_next = byte_count_reg + 16'd1;
            if (link_type == LINK_ETH && byte_count_reg == 16'd12) begin
                ethertype_ok_next = (b == ETHERTYPE_HI);
            end
            if (link_type == LINK_ETH && byte_count_reg == 16'd13) begin
                ethertype_ok_next = ethertype_ok_reg && (b == ETHERTYPE_LO);
            end
            if (link_type != LINK_NONE && byte_count_reg >= {11'd0, io}) begin
                if (r == 16'd0) begin
                    vih_next = b;
                end else if (r == 16'd2) begin
                    total_next[15:8] = b;
                end else if (r == 16'd3) begin
                    total_next[7:0] = b;
                end else if (r == 16'd9) begin
                    proto_next = b;
                end else if (r >= 16'd12 && r <= 16'd15) begin
                    src_next[8*r[1:0] +: 8] = b;
                end else if (r >= 16'd16 && r <= 16'd19) begin
                    dst_next[8*r[1:0] +: 8] = b;
                end
                // TCP header, located by the IHL captured earlier
                if (ihl4 >= MIN_HDR_LEN && r >= {10'd0, ihl4}) begin
                    if (t == 16'd0) begin
                        ports_next[15:8] = b;
                    end else if (t == 16'd1) begin
                        ports_next[7:0] = b;
                    end else if (t == 16'd2) begin
                        ports_next[31:24] = b;
                    end else if (t == 16'd3) begin
                        ports_next[23:16] = b;
                    end else if (t >= 16'd4 && t <= 16'd11) begin
                        seq_ack_next[8*sa_lane +: 8] = b;
                    end else if (t == 16'd12) begin
                        ofw_next[7:0] = b;
                    end else if (t == 16'd13) begin
                        ofw_next[15:8] = b;
                    end else if (t == 16'd14) begin
                        ofw_next[31:24] = b;
                    end else if (t == 16'd15) begin
                        ofw_next[23:16] = b;
                    end
                end
            end
        end
    end

    always_comb begin
        snap.link_type       = link_type;
        snap.overlong        = overlong;
        snap.ethertype_ok    = ethertype_ok_next;
        snap.version_and_ihl = vih_next;
        snap.protocol_byte   = proto_next;
        snap.ip_total_length = total_next;
        snap.src_addr        = src_next;
        snap.dst_addr        = dst_next;
        snap.ports           = ports_next;
        snap.seq_ack         = seq_ack_next;
        snap.off_flags_win   = ofw_next;
        snap.cap_len         = byte_count_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (in_xfer && in_data.last_byte)) begin
            byte_count_reg   <= '0;
            ethertype_ok_reg <= 1'b0;
            vih_reg          <= '0;
            proto_reg        <= '0;
            total_reg        <= '0;
            src_reg          <= '0;
            dst_reg          <= '0;
            ports_reg        <= '0;
            seq_ack_reg      <= '0;
            ofw_reg          <= '0;
        end else if (in_xfer) begin
            byte_count_reg   <= byte_count_next;
            ethertype_ok_reg <= ethertype_ok_next;
            vih_reg          <= vih_next;
            proto_reg        <= proto_next;
            total_reg        <= total_next;
            src_reg          <= src_next;
            dst_reg          <= dst_next;
            ports_reg        <= ports_next;
            seq_ack_reg      <= seq_ack_next;
            ofw_reg          <= ofw_next;
        end
    end

endmodule

// ===== hdl/ithx_check.sv =====
// Frame checks and summary fields for one finished frame.
module ithx_check (
    input  ithx_pkg::ithx_snap_t snap,
    output ithx_pkg::ithx_out_t  result
);
    import ithx_pkg::*;

    logic [4:0]  io;
    logic [16:0] cap17;
    logic [5:0]  ihl4;
    logic [5:0]  thl;
    logic [6:0]  hdr;
    logic [7:0]  po;
    logic [15:0] total_eff;
    logic [15:0] pl_raw;
    logic [15:0] avail;
    logic [15:0] pl;
    logic        ok_link, ok_min, ok_ver, ok_ihl, ok_proto, ok_total, ok_tcp, ok_thl;
    logic        ok;

    assign io        = ip_start(snap.link_type);
    assign cap17     = {1'b0, snap.cap_len};
    assign ihl4      = {snap.version_and_ihl[3:0], 2'b00};
    assign thl       = {snap.off_flags_win[7:4], 2'b00};
    assign hdr       = {1'b0, ihl4} + {1'b0, thl};
    assign po        = {3'd0, io} + {1'b0, hdr};
    assign total_eff = (snap.ip_total_length == 16'd0) ? snap.cap_len - {11'd0, io}
                                                       : snap.ip_total_length;
    assign pl_raw    = (total_eff < {9'd0, hdr}) ? 16'd0 : total_eff - {9'd0, hdr};
    assign avail     = snap.cap_len - {8'd0, po};
    assign pl        = (avail < pl_raw) ? avail : pl_raw;

    assign ok_link  = !snap.overlong && snap.link_type != LINK_NONE
                      && (snap.link_type != LINK_ETH || snap.ethertype_ok);
    assign ok_min   = cap17 >= {12'd0, io} + {11'd0, MIN_HDR_LEN};
    assign ok_ver   = snap.version_and_ihl[7:4] == IP_VERSION;
    assign ok_ihl   = ihl4 >= MIN_HDR_LEN && cap17 >= {12'd0, io} + {11'd0, ihl4};
    assign ok_proto = snap.protocol_byte == PROTO_TCP;
    assign ok_total = cap17 >= {12'd0, io} + {1'b0, total_eff};
    assign ok_tcp   = cap17 >= {12'd0, io} + {11'd0, ihl4} + {11'd0, MIN_HDR_LEN};
    assign ok_thl   = thl >= MIN_HDR_LEN && cap17 >= {9'd0, po};
    assign ok       = ok_link && ok_min && ok_ver && ok_ihl && ok_proto
                      && ok_total && ok_tcp && ok_thl;

    always_comb begin
        result = '0;
        if (ok) begin
            result.accepted       = 1'b1;
            result.source_address = snap.src_addr;
            result.dest_address   = snap.dst_addr;
            result.source_port    = snap.ports[15:0];
            result.dest_port      = snap.ports[31:16];
            result.sequence_word  = snap.seq_ack[31:0];
            result.ack_word       = snap.seq_ack[63:32];
            result.tcp_flag_bits  = snap.off_flags_win[15:8];
            result.window_size    = snap.off_flags_win[31:16];
            result.payload_start  = po;
            result.payload_length = pl;
        end
    end

endmodule

// ===== hdl/ipv4_tcp_header_extract.sv =====
// Top level of the IPv4/TCP header extractor: handshakes, link register, result register.
//
// Input channel (s_): one frame byte per transfer, last_byte set on the final one.
// A byte can be taken every cycle while s_ready is high; header fields are captured
// at fixed offsets as the bytes pass, located from the link type and IPv4 header length.
// Output channel (m_): one summary per frame, produced after the last byte.
// After the last byte's transfer the finished header state is loaded into snap_reg,
// and the checked summary moves into the output register once that register is free.
// Bytes are taken at one per cycle while s_ready is high, with no gap between frames.
// The user writes link_type via cfg_wr_en/cfg_wr_data only while no frame is open; the
// block does not check it; 0 Ethernet, 1 cooked capture, 2 raw IPv4, 3 drops every frame.
// Reset clears the link type to Ethernet, the byte counter, all captured
// fields and the valid flags of both result stages.
// When m_ready is low the summary waits in the output register; a second
// finished frame waits in the stage before it, and only then does s_ready drop.
// Frames longer than 65535 bytes saturate the counter and are rejected.
module ipv4_tcp_header_extract (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [1:0]          cfg_wr_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  ithx_pkg::ithx_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output ithx_pkg::ithx_out_t m_data
);
    import ithx_pkg::*;

    logic [1:0] link_type_reg;
    logic       e_valid_reg, e_valid_next;
    ithx_snap_t snap_reg;
    ithx_snap_t snap_next;
    logic       m_valid_reg, m_valid_next;
    ithx_out_t  m_data_reg;
    ithx_out_t  result;
    logic       o_free, e_free, s_xfer, last_xfer;

    assign o_free    = !m_valid_reg || m_ready;
    assign e_free    = !e_valid_reg || o_free;
    assign s_ready   = e_free;
    assign s_xfer    = s_valid && s_ready;
    assign last_xfer = s_xfer && s_data.last_byte;

    assign e_valid_next = last_xfer || (e_valid_reg && !o_free);
    assign m_valid_next = o_free ? e_valid_reg : m_valid_reg;

    ithx_capture u_capture (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .link_type (link_type_reg),
        .in_data   (s_data),
        .in_xfer   (s_xfer),
        .snap      (snap_next)
    );

    ithx_check u_check (
        .snap   (snap_reg),
        .result (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            link_type_reg <= LINK_ETH;
            e_valid_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                link_type_reg <= cfg_wr_data;
            end
            e_valid_reg <= e_valid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (last_xfer) begin
            snap_reg <= snap_next;
        end
        if (o_free) begin
            m_data_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_last_loads_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        last_xfer |=> e_valid_reg)
        else $error("finished frame not held for checking");

    a_stage_moves_on: assert property (@(posedge aclk) disable iff (!aresetn)
        (e_valid_reg && o_free) |=> m_valid_reg)
        else $error("checked summary lost between stages");

    a_reject_zeroed: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_data_reg.accepted) |-> (m_data_reg.payload_length == 16'd0
            && m_data_reg.payload_start == 8'd0 && m_data_reg.source_address == 32'd0))
        else $error("rejected frame carries field data");

    a_accept_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.accepted) |-> (m_data_reg.payload_start >= 8'd40))
        else $error("accepted frame with payload inside the headers");

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for ipv4_tcp_header_extract: directed frames, then random frames.
`timescale 1ns / 1ps

module testbench;
    import ithx_pkg::*;

    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int TOT_AUTO = -1;
    localparam int NO_CUT = -1;
    localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
    localparam logic [15:0] ETYPE_ARP = 16'h0806;
    localparam logic [15:0] ETYPE_BOGUS = 16'h0900;
    localparam logic [7:0] PROTO_UDP = 8'd17;

    typedef logic [7:0] octets_t [$];

    // One frame recipe; drop marks rows whose summary is all zero.
    typedef struct packed {
        logic [1:0]  link;
        logic [15:0] ethertype;
        logic [7:0]  ver_ihl;
        logic [7:0]  proto;
        int          tot;
        logic [3:0]  doff;
        logic [7:0]  flags;
        int          pay_len;
        int          cut;
        logic        drop;
    } frame_row_t;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      cfg_wr_en = 1'b0;
    logic [1:0] cfg_wr_data = LINK_ETH;
    logic      s_valid = 1'b0;
    logic      s_ready;
    ithx_in_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    ithx_out_t m_data;

    ipv4_tcp_header_extract i_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Predictor state
    logic [1:0]  link_now = LINK_ETH;
    logic [15:0] cur_count;
    logic        cur_eth_ok;
    logic [7:0]  cur_vihl;
    logic [7:0]  cur_proto;
    logic [15:0] cur_total;
    logic [31:0] cur_src;
    logic [31:0] cur_dst;
    logic [31:0] cur_ports;
    logic [63:0] cur_seq_ack;
    logic [31:0] cur_ofw;

    ithx_out_t expected_summaries [$];
    ithx_out_t want_summ;
    int        mismatches = 0;
    int        seen = 0;
    int        cycles = 0;
    bit        calm = 1'b0;

    frame_row_t plan [21] = '{
        '{LINK_ETH, ETYPE_IPV4, 8'h45, PROTO_TCP, TOT_AUTO, 4'd5, 8'h18, 12, NO_CUT, 1'b0},
        '{LINK_ETH, ETYPE_BOGUS, 8'h45, PROTO_TCP, TOT_AUTO, 4'd5, 8'h10, 4, NO_CUT, 1'b1},
        '{LINK_ETH, ETYPE_ARP, 8'h45, PROTO_TCP, TOT_AUTO, 4'd5, 8'h10, 4, NO_CUT, 1'b1},
        '{LINK_ETH, ETYPE_IPV4, 8'h65, PROTO_TCP, TOT_AUTO, 4'd5, 8'h10, 4, NO_CUT, 1'b1},
        '{LINK_ETH, ETYPE_IPV4, 8'h44, PROTO_TCP, TOT_AUTO, 4'd5, 8'h10, 4, NO_CUT, 1'b1},
        '{LINK_ETH, ETYPE_IPV4, 8'h45, PROTO_UDP, TOT_AUTO, 4'd5, 8'h10, 4, NO_CUT, 1'b1},
        '{LINK_ETH, ETYPE_IPV4, 8'h45, PROTO_TCP, TOT_AUTO, 4'd4, 8'h10, 4, NO_CUT, 1'b1},
        '{LINK_ETH, ETYPE_IPV4, 8'h4f, PROTO_TCP, TOT_AUTO, 4'd15, 8'hff, 0, NO_CUT, 1'b0},
        '{LINK_ETH, ETYPE_IPV4, 8'h45, PROTO_TCP, 0, 4'd5, 8'h00, 9, NO_CUT, 1'b0},
        '{LINK_ETH, ETYPE_IPV4, 8'h45, PROTO_TCP, 30, 4'd5, 8'h02, 6, NO_CUT, 1'b0},
        '{LINK_ETH, ETYPE_IPV4, 8'h45, PROTO_TCP, 40, 4'd5, 8'h11, 8, NO_CUT, 1'b0},
        '{LINK_ETH, ETYPE_IPV4, 8'h45, PROTO_TCP, 65535, 4'd5, 8'h10, 3, NO_CUT, 1'b1},
        '{LINK_ETH, ETYPE_IPV4, 8'h45, PROTO_TCP, TOT_AUTO, 4'd5, 8'h18, 20, 59, 1'b1},
        '{LINK_ETH, ETYPE_IPV4, 8'h45, PROTO_TCP, TOT_AUTO, 4'd5, 8'h18, 0, 30, 1'b1},
        '{LINK_ETH, ETYPE_IPV4, 8'h46, PROTO_TCP, TOT_AUTO, 4'd5, 8'h18, 0, 48, 1'b1},
        '{LINK_ETH, ETYPE_IPV4, 8'h45, PROTO_TCP, TOT_AUTO, 4'd5, 8'h18, 0, 1, 1'b1},
        '{LINK_SLL, ETYPE_IPV4, 8'h45, PROTO_TCP, TOT_AUTO, 4'd8, 8'h12, 5, NO_CUT, 1'b0},
        '{LINK_RAW, ETYPE_IPV4, 8'h45, PROTO_TCP, TOT_AUTO, 4'd5, 8'h29, 1, NO_CUT, 1'b0},
        '{LINK_RAW, ETYPE_IPV4, 8'h45, PROTO_TCP, 0, 4'd5, 8'h01, 0, NO_CUT, 1'b0},
        '{LINK_RAW, ETYPE_IPV4, 8'h45, PROTO_TCP, TOT_AUTO, 4'd5, 8'h10, 0, 39, 1'b1},
        '{LINK_NONE, ETYPE_IPV4, 8'h45, PROTO_TCP, TOT_AUTO, 4'd5, 8'h18, 4, NO_CUT, 1'b1}
    };

    logic [1:0] phase_links [7] = '{LINK_RAW, LINK_SLL, LINK_ETH, LINK_NONE,
                                    LINK_RAW, LINK_ETH, LINK_SLL};

    function automatic int hdr_base(input logic [1:0] lt);
        if (lt == LINK_ETH) return int'(IP_OFF_ETH);
        if (lt == LINK_SLL) return int'(IP_OFF_SLL);
        return int'(IP_OFF_RAW);
    endfunction

    function automatic void forget_frame();
        cur_count = '0;
        cur_eth_ok = 1'b0;
        cur_vihl = '0;
        cur_proto = '0;
        cur_total = '0;
        cur_src = '0;
        cur_dst = '0;
        cur_ports = '0;
        cur_seq_ack = '0;
        cur_ofw = '0;
    endfunction

    function automatic void capture_field(input int pos, input logic [7:0] b);
        int base, r, t, ihl4;
        base = hdr_base(link_now);
        if (link_now == LINK_ETH && pos == 12) cur_eth_ok = (b == ETHERTYPE_HI);
        if (link_now == LINK_ETH && pos == 13) cur_eth_ok = cur_eth_ok && (b == ETHERTYPE_LO);
        if (link_now == LINK_NONE || pos < base) return;
        r = pos - base;
        if (r == 0) cur_vihl = b;
        else if (r == 2) cur_total[15:8] = b;
        else if (r == 3) cur_total[7:0] = b;
        else if (r == 9) cur_proto = b;
        else if (r >= 12 && r <= 15) cur_src[8*(r-12) +: 8] = b;
        else if (r >= 16 && r <= 19) cur_dst[8*(r-16) +: 8] = b;
        ihl4 = int'(cur_vihl[3:0]) * 4;
        if (ihl4 < 20 || r < ihl4) return;
        t = r - ihl4;
        case (t)
            0: cur_ports[15:8] = b;
            1: cur_ports[7:0] = b;
            2: cur_ports[31:24] = b;
            3: cur_ports[23:16] = b;
            12: cur_ofw[7:0] = b;
            13: cur_ofw[15:8] = b;
            14: cur_ofw[31:24] = b;
            15: cur_ofw[23:16] = b;
            default: if (t >= 4 && t <= 11) cur_seq_ack[8*(t-4) +: 8] = b;
        endcase
    endfunction

    function automatic bit predict_summary(input logic [7:0] b, input logic lst,
                                           output ithx_out_t summ);
        bit over;
        int cap, base, ihl4, thl, total, po, pl;
        summ = '0;
        over = (cur_count == MAX_FRAME_BYTES);
        if (!over) begin
            capture_field(int'(cur_count), b);
            cur_count++;
        end
        if (!lst) return 1'b0;
        cap = int'(cur_count);
        base = hdr_base(link_now);
        ihl4 = int'(cur_vihl[3:0]) * 4;
        thl = int'(cur_ofw[7:4]) * 4;
        total = (cur_total == 0) ? cap - base : int'(cur_total);
        if (!over && link_now != LINK_NONE && cap >= base + 20
                && (link_now != LINK_ETH || cur_eth_ok)
                && cur_vihl[7:4] == IP_VERSION && ihl4 >= 20 && cap >= base + ihl4
                && cur_proto == PROTO_TCP && cap >= base + total
                && cap >= base + ihl4 + 20 && thl >= 20 && cap >= base + ihl4 + thl) begin
            po = base + ihl4 + thl;
            pl = (total < ihl4 + thl) ? 0 : total - ihl4 - thl;
            if (cap < po + pl) pl = cap - po;
            summ.accepted = 1'b1;
            summ.source_address = cur_src;
            summ.dest_address = cur_dst;
            summ.source_port = cur_ports[15:0];
            summ.dest_port = cur_ports[31:16];
            summ.sequence_word = cur_seq_ack[31:0];
            summ.ack_word = cur_seq_ack[63:32];
            summ.tcp_flag_bits = cur_ofw[15:8];
            summ.window_size = cur_ofw[31:16];
            summ.payload_start = 8'(po);
            summ.payload_length = 16'(pl);
        end
        forget_frame();
        return 1'b1;
    endfunction

    function automatic octets_t build_frame(input frame_row_t fr);
        octets_t f;
        int ip_len, tcp_len;
        logic [15:0] tot_w;
        ip_len = int'(fr.ver_ihl[3:0]) * 4;
        if (ip_len < 20) ip_len = 20;
        tcp_len = int'(fr.doff) * 4;
        if (tcp_len < 20) tcp_len = 20;
        tot_w = (fr.tot == TOT_AUTO) ? 16'(ip_len + tcp_len + fr.pay_len) : 16'(fr.tot);
        if (fr.link == LINK_ETH || fr.link == LINK_SLL) begin
            repeat (fr.link == LINK_ETH ? 12 : 14) f.push_back(8'($urandom));
            f.push_back(fr.ethertype[15:8]);
            f.push_back(fr.ethertype[7:0]);
        end
        for (int i = 0; i < ip_len; i++) begin
            case (i)
                0: f.push_back(fr.ver_ihl);
                2: f.push_back(tot_w[15:8]);
                3: f.push_back(tot_w[7:0]);
                9: f.push_back(fr.proto);
                default: f.push_back(8'($urandom));
            endcase
        end
        for (int i = 0; i < tcp_len; i++) begin
            case (i)
                12: f.push_back({fr.doff, 4'($urandom)});
                13: f.push_back(fr.flags);
                default: f.push_back(8'($urandom));
            endcase
        end
        repeat (fr.pay_len) f.push_back(8'($urandom));
        if (fr.cut != NO_CUT) begin
            while (f.size() > fr.cut) f.delete(f.size() - 1);
        end
        return f;
    endfunction

    // Mostly well-formed headers with random content, some broken on purpose.
    function automatic frame_row_t rand_row(input logic [1:0] lt);
        frame_row_t fr;
        fr.link = lt;
        fr.ethertype = ETYPE_IPV4;
        fr.ver_ihl = {IP_VERSION, $urandom_range(0, 1) ? 4'd5 : 4'($urandom_range(5, 15))};
        fr.proto = PROTO_TCP;
        fr.tot = TOT_AUTO;
        fr.doff = $urandom_range(0, 1) ? 4'd5 : 4'($urandom_range(5, 15));
        fr.flags = 8'($urandom);
        fr.pay_len = $urandom_range(0, 24);
        fr.cut = NO_CUT;
        fr.drop = 1'b0;
        case ($urandom_range(0, 13))
            0: fr.tot = 0;
            1: fr.tot = $urandom_range(0, 90);
            2: fr.cut = $urandom_range(1, 100);
            3: fr.ethertype = 16'($urandom);
            4: fr.ver_ihl = 8'($urandom);
            5: fr.proto = 8'($urandom);
            6: fr.doff = 4'($urandom);
            default: ;
        endcase
        return fr;
    endfunction

    task automatic put_byte(input logic [7:0] b, input logic lst);
        int gap;
        ithx_in_t item;
        gap = calm ? 0 : $urandom_range(0, 12);
        item.data_byte = b;
        item.last_byte = lst;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= item;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_frame(input octets_t fb, input logic drop);
        ithx_out_t summ;
        logic lst;
        for (int i = 0; i < fb.size(); i++) begin
            lst = (i == fb.size() - 1);
            put_byte(fb[i], lst);
            if (predict_summary(fb[i], lst, summ))
                expected_summaries.push_back(drop ? ithx_out_t'('0) : summ);
        end
    endtask

    // Link type only changes once the pipeline has drained.
    task automatic write_link_type(input logic [1:0] lt);
        s_valid <= 1'b0;
        while (expected_summaries.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= lt;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        link_now = lt;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
                $display("summary %0d: %s expected %h got %h", seen, name, want, got);
        end
    endtask

    always @(posedge aclk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            seen++;
            if (expected_summaries.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("summary %0d: none expected, got %h", seen, m_data);
            end else begin
                want_summ = expected_summaries.pop_front();
                check_field("accepted", want_summ.accepted, m_data.accepted);
                check_field("source_address", want_summ.source_address, m_data.source_address);
                check_field("dest_address", want_summ.dest_address, m_data.dest_address);
                check_field("source_port", want_summ.source_port, m_data.source_port);
                check_field("dest_port", want_summ.dest_port, m_data.dest_port);
                check_field("sequence_word", want_summ.sequence_word, m_data.sequence_word);
                check_field("ack_word", want_summ.ack_word, m_data.ack_word);
                check_field("tcp_flag_bits", want_summ.tcp_flag_bits, m_data.tcp_flag_bits);
                check_field("window_size", want_summ.window_size, m_data.window_size);
                check_field("payload_start", want_summ.payload_start, m_data.payload_start);
                check_field("payload_length", want_summ.payload_length, m_data.payload_length);
            end
        end
    end

    // Result side: random stall before each transfer, none while calm
    initial begin
        int gap;
        while (!aresetn) @(posedge aclk);
        forever begin
            gap = calm ? 0 : $urandom_range(0, 12);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    initial begin
        octets_t fb;
        forget_frame();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (plan[i]) begin
            if (plan[i].link != link_now) write_link_type(plan[i].link);
            calm = ($urandom_range(0, 3) == 0);
            send_frame(build_frame(plan[i]), plan[i].drop);
        end

        foreach (phase_links[p]) begin
            write_link_type(phase_links[p]);
            calm = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) == 0) begin
                fb.delete();
                repeat ($urandom_range(1, 40)) fb.push_back(8'($urandom));
            end else begin
                fb = build_frame(rand_row(phase_links[p]));
            end
            send_frame(fb, 1'b0);
        end

        s_valid <= 1'b0;
        while (expected_summaries.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (mismatches == 0 && expected_summaries.size() == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/ithx_pkg.sv
hdl/ithx_capture.sv
hdl/ithx_check.sv
hdl/ipv4_tcp_header_extract.sv
tb/testbench.sv
